FILE: rtl/sba_pkg.sv
// Shared types and constants of the slab bump allocator.
`default_nettype none

package sba_pkg;

    localparam int BYTES_W  = 25;
    localparam int ADDR_W   = 28;
    localparam int TAG_W    = 8;
    localparam int TOTAL_W  = 29;
    localparam int COUNT_W  = 32;
    localparam int LIMIT_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 152;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SLAB_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAB_LIMIT = 2'd1;

    localparam logic [BYTES_W-1:0] SLAB_BYTES_RST = 25'd1048576;
    localparam logic [LIMIT_W-1:0] SLAB_LIMIT_RST = 5'd16;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_NEW      = 3'd1,
        ST_NO_SLAB  = 3'd2,
        ST_ZERO     = 3'd3,
        ST_FREE_OK  = 3'd4,
        ST_FREE_BAD = 3'd5
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/slab_bump_allocator.sv
// Top level of the slab bump allocator: request sequencer, slab scan and totals.
`default_nettype none

// Allocate requests scan the slabs in index order, one slab per cycle, through
// the single read port of the slab table; the first active slab with room wins
// and the scan stops there. A nonzero allocate then passes an update step, also
// when no slab has room. A zero-size allocate goes straight to the result; a
// free checks its address and, when it touches a slab, updates that slab.
// The request side is ready only between requests; a finished result sits in
// an output register, so a new request may be taken while it waits.
// Configuration writes are taken only between requests and apply from the
// next request on.
module slab_bump_allocator
    import sba_pkg::*;
#(
    parameter int NUM_SLABS      = 16,
    parameter int SLAB_SPAN_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request: byte_count[24:0], free_address[52:25], stream_tag[60:53]
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // request: command[0]
    input  wire logic                  i_s_axis_tuser,
    // result: granted_address[27:0], bytes_in_use[56:28], peak_bytes[85:57],
    // hit_count[117:86], miss_count[149:118]
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [OUT_DATA_W-1:0] o_m_axis_tdata,
    // result: status[2:0]
    output logic      [2:0]            o_m_axis_tuser,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [BYTES_W-1:0]    i_cfg_data
);

    localparam int IW = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int CW = $clog2(NUM_SLABS + 1);
    localparam int WORD_W = TAG_W + BYTES_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLABS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_FREE,
        S_FCHK,
        S_EMIT
    } t_state;

    function automatic logic [BYTES_W-1:0] f_size(input logic [BYTES_W-1:0] b);
        logic [32:0] span;
        logic [32:0] v;
        span = 33'd1 << SLAB_SPAN_BITS;
        v = 33'(b);
        if (v == 33'd0) begin
            v = 33'd1;
        end
        if (v > span) begin
            v = span;
        end
        return v[BYTES_W-1:0];
    endfunction

    function automatic logic [CW-1:0] f_limit(input logic [LIMIT_W-1:0] l);
        logic [7:0] v;
        v = 8'(l);
        if (v == 8'd0) begin
            v = 8'd1;
        end
        if (v > 8'(NUM_SLABS)) begin
            v = 8'(NUM_SLABS);
        end
        return v[CW-1:0];
    endfunction

    t_state               r_state;
    t_status              r_status;
    logic [BYTES_W-1:0]   r_size;
    logic [CW-1:0]        r_limit;
    logic [NUM_SLABS-1:0] r_active;
    logic [CW-1:0]        r_active_cnt;
    logic [TOTAL_W-1:0]   r_in_use;
    logic [TOTAL_W-1:0]   r_peak;
    logic [COUNT_W-1:0]   r_hits;
    logic [COUNT_W-1:0]   r_misses;

    logic [BYTES_W-1:0]   r_bytes;
    logic [ADDR_W-1:0]    r_addr;
    logic [TAG_W-1:0]     r_tag;

    logic [IW-1:0]        r_scan_idx;
    logic [IW-1:0]        r_chk_idx;
    logic                 r_chk_vld;
    logic                 r_free_found;
    logic [IW-1:0]        r_free_idx;
    logic [IW-1:0]        r_pick;
    logic [BYTES_W-1:0]   r_pick_off;
    logic [ADDR_W-1:0]    r_grant;

    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [2:0]            r_out_user;

    logic                 in_accept;
    logic [WORD_W-1:0]    ram_rdata;
    logic [BYTES_W-1:0]   rd_off;
    logic [TAG_W-1:0]     rd_tag;
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [IW-1:0]        ram_raddr;

    logic [BYTES_W:0]     fit_sum;
    logic                 fit;
    logic [BYTES_W-1:0]   upd_off;
    logic [TOTAL_W:0]     add_sum;
    logic [TOTAL_W-1:0]   add_sat;
    logic [63:0]          grant_wide;

    logic [63:0]          f_idx_wide;
    logic [63:0]          f_low_wide;
    logic [IW-1:0]        f_idx;
    logic                 f_ok;
    logic                 f_over;
    logic [BYTES_W-1:0]   f_take;
    logic [BYTES_W-1:0]   f_new_off;
    logic [TOTAL_W-1:0]   f_in_use;

    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    assign rd_off = ram_rdata[BYTES_W-1:0];
    assign rd_tag = ram_rdata[WORD_W-1:BYTES_W];

    // shared compare unit for the scan
    assign fit_sum = {1'b0, rd_off} + {1'b0, r_bytes};
    assign fit     = r_active[r_chk_idx] && (fit_sum <= {1'b0, r_size});

    assign upd_off    = r_pick_off + r_bytes;
    assign add_sum    = {1'b0, r_in_use} + (TOTAL_W + 1)'(r_bytes);
    assign add_sat    = add_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : add_sum[TOTAL_W-1:0];
    assign grant_wide = (64'(r_pick) << SLAB_SPAN_BITS) + 64'(r_pick_off);

    assign f_idx_wide = 64'(r_addr) >> SLAB_SPAN_BITS;
    assign f_low_wide = 64'(r_addr) & ((64'd1 << SLAB_SPAN_BITS) - 64'd1);
    assign f_idx      = f_idx_wide[IW-1:0];
    assign f_ok       = (f_idx_wide < 64'(NUM_SLABS)) && r_active[f_idx]
                        && (f_low_wide < 64'(r_size));
    assign f_over     = r_bytes > rd_off;
    assign f_take     = f_over ? rd_off : r_bytes;
    assign f_new_off  = rd_off - f_take;
    assign f_in_use   = (TOTAL_W'(f_take) > r_in_use) ? '0 : r_in_use - TOTAL_W'(f_take);

    always_comb begin
        ram_raddr = (r_state == S_FREE) ? f_idx : r_scan_idx;
        ram_we    = 1'b0;
        ram_waddr = r_pick;
        ram_wdata = {r_tag, upd_off};
        case (r_state)
            S_UPD: begin
                ram_we = (r_status != ST_NO_SLAB);
            end
            S_FCHK: begin
                ram_we    = 1'b1;
                ram_wdata = (f_new_off == '0) ? '0 : {rd_tag, f_new_off};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    sba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_SLABS)
    ) u_slab_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_status     <= ST_HIT;
            r_size       <= f_size(SLAB_BYTES_RST);
            r_limit      <= f_limit(SLAB_LIMIT_RST);
            r_active     <= '0;
            r_active_cnt <= '0;
            r_in_use     <= '0;
            r_peak       <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_out_vld    <= 1'b0;
            r_chk_vld    <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SLAB_BYTES: r_size  <= f_size(i_cfg_data);
                    CFG_SLAB_LIMIT: r_limit <= f_limit(i_cfg_data[LIMIT_W-1:0]);
                    default: ;
                endcase
            end

            if (r_state == S_EMIT && (!r_out_vld || i_m_axis_tready)) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_bytes      <= i_s_axis_tdata[24:0];
                        r_addr       <= i_s_axis_tdata[52:25];
                        r_tag        <= i_s_axis_tdata[60:53];
                        r_grant      <= '0;
                        r_scan_idx   <= '0;
                        r_chk_vld    <= 1'b0;
                        r_free_found <= 1'b0;
                        if (i_s_axis_tuser == CMD_FREE) begin
                            r_state <= S_FREE;
                        end else if (i_s_axis_tdata[24:0] == '0) begin
                            r_status <= ST_ZERO;
                            r_state  <= S_EMIT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_scan_idx != LAST_IDX) begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                    r_chk_idx <= r_scan_idx;
                    r_chk_vld <= 1'b1;
                    if (r_chk_vld) begin
                        if (!r_active[r_chk_idx] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_chk_idx;
                        end
                        if (fit) begin
                            r_pick     <= r_chk_idx;
                            r_pick_off <= rd_off;
                            r_status   <= ST_HIT;
                            r_state    <= S_UPD;
                        end else if (r_chk_idx == LAST_IDX) begin
                            r_pick_off <= '0;
                            r_state    <= S_UPD;
                            if (r_bytes <= r_size && r_active_cnt < r_limit
                                && (r_free_found || !r_active[r_chk_idx])) begin
                                r_status <= ST_NEW;
                                r_pick   <= r_free_found ? r_free_idx : r_chk_idx;
                            end else begin
                                r_status <= ST_NO_SLAB;
                            end
                        end
                    end
                end
                S_UPD: begin
                    if (r_status == ST_HIT) begin
                        r_hits <= r_hits + 1'b1;
                    end else begin
                        r_misses <= r_misses + 1'b1;
                    end
                    if (r_status != ST_NO_SLAB) begin
                        r_grant            <= grant_wide[ADDR_W-1:0];
                        r_active[r_pick]   <= 1'b1;
                        r_in_use           <= add_sat;
                        if (add_sat > r_peak) begin
                            r_peak <= add_sat;
                        end
                        if (r_status == ST_NEW) begin
                            r_active_cnt <= r_active_cnt + 1'b1;
                        end
                    end
                    r_state <= S_EMIT;
                end
                S_FREE: begin
                    r_pick <= f_idx;
                    if (f_ok) begin
                        r_state <= S_FCHK;
                    end else begin
                        r_status <= ST_FREE_BAD;
                        r_state  <= S_EMIT;
                    end
                end
                S_FCHK: begin
                    r_status <= f_over ? ST_FREE_BAD : ST_FREE_OK;
                    r_in_use <= f_in_use;
                    if (f_new_off == '0) begin
                        r_active[r_pick] <= 1'b0;
                        r_active_cnt     <= r_active_cnt - 1'b1;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_vld || i_m_axis_tready) begin
                        r_out_user <= r_status;
                        r_out_data <= {2'b00, r_misses, r_hits, r_peak, r_in_use, r_grant};
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sba_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module sba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
